### rtl/core/lqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_pkg
// shared types, constants and state codes for the lighting metrics block
// ----------------------------------------------------------------------------
package lqm_pkg;

    localparam int PowerW   = 16;
    localparam int PeriodW  = 20;
    localparam int LuxW     = 16;
    localparam int DutyW    = 8;
    localparam int EnergyW  = 48;
    localparam int CountW   = 32;
    localparam int OpW      = 32;
    localparam int DenW     = OpW + 1;
    localparam int AccW     = 2 * OpW + 1;
    localparam int CntW     = 7;
    localparam int CfgDataW = 20;

    localparam logic [PowerW-1:0]  PowerReset  = 16'd1000;
    localparam logic [PeriodW-1:0] PeriodReset = 20'd10000;
    localparam logic [DenW-1:0]    DutyFull    = 33'd255;
    localparam logic [OpW-1:0]     UsPerSecond = 32'd1000000;

    localparam logic CfgIdxPower  = 1'b0;
    localparam logic CfgIdxPeriod = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GO,
        ST_WAIT,
        ST_DONE
    } lqm_state_t;

    typedef enum logic [1:0] {
        OP_ENERGY,
        OP_VIS,
        OP_FSIZE,
        OP_FMEAN
    } lqm_op_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } lqm_md_state_t;

    // operands of one (a * b + c) / d job
    typedef struct packed {
        logic            start;
        logic [OpW-1:0]  a;
        logic [OpW-1:0]  b;
        logic [OpW-1:0]  c;
        logic [DenW-1:0] d;
    } lqm_md_req_t;

    typedef struct packed {
        logic            done;
        logic [AccW-1:0] quot;
    } lqm_md_rsp_t;

endpackage

### rtl/core/lqm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_if
// request and result channels of the lighting metrics block
// ----------------------------------------------------------------------------
interface lqm_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] lux_measured;
    logic [15:0] lux_reference;
    logic [7:0]  duty;

    modport source (output valid, command, lux_measured, lux_reference, duty, input ready);
    modport sink   (input valid, command, lux_measured, lux_reference, duty, output ready);
endinterface

interface lqm_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] energy_nj;
    logic [15:0] visibility_error;
    logic [31:0] flicker_error;
    logic [31:0] sample_count;

    modport source (output valid, energy_nj, visibility_error, flicker_error, sample_count,
                    input ready);
    modport sink   (input valid, energy_nj, visibility_error, flicker_error, sample_count,
                    output ready);
endinterface

### rtl/core/lqm_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqm_muldiv
// bit-serial (a * b + c) / d: shift-add multiply then restoring divide
// ----------------------------------------------------------------------------
module lqm_muldiv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lqm_pkg::lqm_md_req_t req,
    output lqm_pkg::lqm_md_rsp_t rsp
);

    lqm_pkg::lqm_md_state_t state_reg, state_next;
    logic [lqm_pkg::AccW-1:0]   acc_reg, acc_next;
    logic [2*lqm_pkg::OpW-1:0]  mcand_reg, mcand_next;
    logic [lqm_pkg::OpW-1:0]    mplier_reg, mplier_next;
    logic [lqm_pkg::DenW-1:0]   den_reg, den_next;
    logic [lqm_pkg::DenW:0]     rem_reg, rem_next;
    logic [lqm_pkg::CntW-1:0]   cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [lqm_pkg::DenW:0]     trial;
    logic                       qbit;

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        trial       = {rem_reg[lqm_pkg::DenW-1:0], acc_reg[lqm_pkg::AccW-1]};
        qbit        = (trial >= {1'b0, den_reg});
        case (state_reg)
            lqm_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    acc_next    = {{(lqm_pkg::AccW-lqm_pkg::OpW){1'b0}}, req.c};
                    mcand_next  = {{lqm_pkg::OpW{1'b0}}, req.a};
                    mplier_next = req.b;
                    den_next    = req.d;
                    cnt_next    = '0;
                    state_next  = lqm_pkg::MD_MUL;
                end
            end
            lqm_pkg::MD_MUL:
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + {1'b0, mcand_reg};
                mcand_next  = {mcand_reg[2*lqm_pkg::OpW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[lqm_pkg::OpW-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == lqm_pkg::CntW'(lqm_pkg::OpW - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = lqm_pkg::MD_DIV;
                end
            end
            lqm_pkg::MD_DIV:
            begin
                rem_next = qbit ? (trial - {1'b0, den_reg}) : trial;
                acc_next = {acc_reg[lqm_pkg::AccW-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lqm_pkg::CntW'(lqm_pkg::AccW - 1))
                begin
                    done_next  = 1'b1;
                    state_next = lqm_pkg::MD_IDLE;
                end
            end
            default:
                state_next = lqm_pkg::MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lqm_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg;

endmodule

### rtl/core/lighting_quality_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lighting_quality_metrics
// energy, visibility and flicker metrics of one luminaire, per sample
// ----------------------------------------------------------------------------
// usage
//   in_req carries one request: a command (process sample or clear all),
//   measured and reference lux and the led duty. out_res returns one result
//   per request: energy in nJ, mean shortfall, mean flicker and sample count.
//   cfg_we / cfg_index / cfg_data write the power and period registers;
//   write them only while the block is idle.
// arithmetic
//   all multiplies and divides run through one bit-serial (a*b+c)/d unit
//   that takes 32 multiply steps and 65 divide steps per job. a sample
//   costs two jobs up to the third sample, then three, or four when a
//   reversal is sized. one request is worked on at a time.
// reset
//   rst_n clears every metric and loads power 1000 mW, period 10000 us.
// back-pressure
//   results sit in an output register; a finished request waits in the
//   done state while out_res is stalled, and in_req is not ready meanwhile.
// ----------------------------------------------------------------------------
module lighting_quality_metrics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [lqm_pkg::CfgDataW-1:0]  cfg_data,
    lqm_in_if.sink                        in_req,
    lqm_out_if.source                     out_res
);

    // configuration
    logic [lqm_pkg::PowerW-1:0]  power_reg;
    logic [lqm_pkg::PeriodW-1:0] period_reg;

    // control
    lqm_pkg::lqm_state_t state_reg, state_next;
    lqm_pkg::lqm_op_t    op_reg, op_next;
    logic                cmd_reg, cmd_next;

    // latched request
    logic [lqm_pkg::LuxW-1:0]  lux_reg, lux_next;
    logic [lqm_pkg::LuxW-1:0]  ref_reg, ref_next;
    logic [lqm_pkg::DutyW-1:0] duty_reg, duty_next;

    // metric state
    logic [lqm_pkg::CountW-1:0]  count_reg, count_next;
    logic [lqm_pkg::LuxW-1:0]    hist0_reg, hist0_next;
    logic [lqm_pkg::LuxW-1:0]    hist1_reg, hist1_next;
    logic [lqm_pkg::EnergyW-1:0] energy_reg, energy_next;
    logic [lqm_pkg::LuxW-1:0]    vis_reg, vis_next;
    logic [lqm_pkg::OpW-1:0]     fmean_reg, fmean_next;
    logic [lqm_pkg::OpW-1:0]     fsize_reg, fsize_next;

    // result register
    logic                        ov_reg, ov_next;
    logic [lqm_pkg::EnergyW-1:0] oe_reg, oe_next;
    logic [lqm_pkg::LuxW-1:0]    ovis_reg, ovis_next;
    logic [lqm_pkg::OpW-1:0]     ofl_reg, ofl_next;
    logic [lqm_pkg::CountW-1:0]  ocnt_reg, ocnt_next;

    lqm_pkg::lqm_md_req_t md_req;
    lqm_pkg::lqm_md_rsp_t md_rsp;

    // flicker test on exact signed differences
    logic                      flick;
    logic [lqm_pkg::LuxW-1:0]  d0_abs, d1_abs;
    logic [lqm_pkg::LuxW:0]    dsum;
    logic [lqm_pkg::EnergyW:0] esum;
    logic [lqm_pkg::DenW-1:0]  count_wide;
    logic                      count_full;
    logic                      req_fire;
    logic [lqm_pkg::PowerW+lqm_pkg::DutyW-1:0] pdu;

    assign flick  = (lux_reg != hist0_reg) && (hist0_reg != hist1_reg)
                    && ((lux_reg > hist0_reg) != (hist0_reg > hist1_reg));
    assign d0_abs = (lux_reg > hist0_reg) ? lux_reg - hist0_reg : hist0_reg - lux_reg;
    assign d1_abs = (hist0_reg > hist1_reg) ? hist0_reg - hist1_reg : hist1_reg - hist0_reg;
    assign dsum   = {1'b0, d0_abs} + {1'b0, d1_abs};
    assign pdu    = power_reg * duty_reg;
    assign count_wide = {1'b0, count_reg};
    assign count_full = &count_reg;
    assign esum   = {1'b0, energy_reg} + md_rsp.quot[lqm_pkg::EnergyW:0];
    assign req_fire = in_req.valid && in_req.ready;

    assign in_req.ready = (state_reg == lqm_pkg::ST_IDLE);

    // operand select for the shared unit
    always_comb
    begin
        md_req.start = (state_reg == lqm_pkg::ST_GO);
        case (op_reg)
            lqm_pkg::OP_ENERGY:
            begin
                md_req.a = {{(lqm_pkg::OpW-lqm_pkg::PowerW-lqm_pkg::DutyW){1'b0}}, pdu};
                md_req.b = {{(lqm_pkg::OpW-lqm_pkg::PeriodW){1'b0}}, period_reg};
                md_req.c = '0;
                md_req.d = lqm_pkg::DutyFull;
            end
            lqm_pkg::OP_VIS:
            begin
                md_req.a = {{(lqm_pkg::OpW-lqm_pkg::LuxW){1'b0}}, vis_reg};
                md_req.b = count_reg;
                md_req.c = (ref_reg > lux_reg)
                           ? {{(lqm_pkg::OpW-lqm_pkg::LuxW){1'b0}}, ref_reg - lux_reg} : '0;
                md_req.d = count_wide + 1'b1;
            end
            lqm_pkg::OP_FSIZE:
            begin
                md_req.a = {{(lqm_pkg::OpW-lqm_pkg::LuxW-1){1'b0}}, dsum};
                md_req.b = lqm_pkg::UsPerSecond;
                md_req.c = '0;
                md_req.d = {{(lqm_pkg::DenW-lqm_pkg::PeriodW-1){1'b0}}, period_reg, 1'b0};
            end
            default:
            begin
                md_req.a = fmean_reg;
                md_req.b = count_reg - 2'd2;
                md_req.c = fsize_reg;
                md_req.d = count_wide - 1'b1;
            end
        endcase
    end

    lqm_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cmd_next    = cmd_reg;
        lux_next    = lux_reg;
        ref_next    = ref_reg;
        duty_next   = duty_reg;
        count_next  = count_reg;
        hist0_next  = hist0_reg;
        hist1_next  = hist1_reg;
        energy_next = energy_reg;
        vis_next    = vis_reg;
        fmean_next  = fmean_reg;
        fsize_next  = fsize_reg;
        ov_next     = ov_reg;
        oe_next     = oe_reg;
        ovis_next   = ovis_reg;
        ofl_next    = ofl_reg;
        ocnt_next   = ocnt_reg;
        if (out_res.ready)
            ov_next = 1'b0;
        case (state_reg)
            lqm_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next  = in_req.command;
                    lux_next  = in_req.lux_measured;
                    ref_next  = in_req.lux_reference;
                    duty_next = in_req.duty;
                    op_next   = lqm_pkg::OP_ENERGY;
                    if (in_req.command)
                    begin
                        // clear request: wipe every metric, report zeros
                        count_next  = '0;
                        hist0_next  = '0;
                        hist1_next  = '0;
                        energy_next = '0;
                        vis_next    = '0;
                        fmean_next  = '0;
                        state_next  = lqm_pkg::ST_DONE;
                    end
                    else
                        state_next = lqm_pkg::ST_GO;
                end
            end
            lqm_pkg::ST_GO:
                state_next = lqm_pkg::ST_WAIT;
            lqm_pkg::ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    case (op_reg)
                        lqm_pkg::OP_ENERGY:
                        begin
                            energy_next = esum[lqm_pkg::EnergyW] ? '1
                                          : esum[lqm_pkg::EnergyW-1:0];
                            op_next     = lqm_pkg::OP_VIS;
                            state_next  = lqm_pkg::ST_GO;
                        end
                        lqm_pkg::OP_VIS:
                        begin
                            vis_next = md_rsp.quot[lqm_pkg::LuxW-1:0];
                            if (count_reg >= 3)
                            begin
                                state_next = lqm_pkg::ST_GO;
                                if (flick && (period_reg != '0))
                                    op_next = lqm_pkg::OP_FSIZE;
                                else
                                begin
                                    // zero period makes a flicker saturate
                                    fsize_next = flick ? '1 : '0;
                                    op_next    = lqm_pkg::OP_FMEAN;
                                end
                            end
                            else
                                state_next = lqm_pkg::ST_DONE;
                        end
                        lqm_pkg::OP_FSIZE:
                        begin
                            fsize_next = (|md_rsp.quot[lqm_pkg::AccW-1:lqm_pkg::OpW]) ? '1
                                         : md_rsp.quot[lqm_pkg::OpW-1:0];
                            op_next    = lqm_pkg::OP_FMEAN;
                            state_next = lqm_pkg::ST_GO;
                        end
                        default:
                        begin
                            fmean_next = md_rsp.quot[lqm_pkg::OpW-1:0];
                            state_next = lqm_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lqm_pkg::ST_DONE:
            begin
                if (!ov_reg || out_res.ready)
                begin
                    ov_next    = 1'b1;
                    oe_next    = energy_reg;
                    ovis_next  = vis_reg;
                    ofl_next   = fmean_reg;
                    ocnt_next  = count_reg;
                    state_next = lqm_pkg::ST_IDLE;
                    if (!cmd_reg)
                    begin
                        hist0_next = lux_reg;
                        hist1_next = hist0_reg;
                        if (!count_full)
                        begin
                            count_next = count_reg + 1'b1;
                            ocnt_next  = count_reg + 1'b1;
                        end
                    end
                end
            end
            default:
                state_next = lqm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lqm_pkg::ST_IDLE;
            op_reg     <= lqm_pkg::OP_ENERGY;
            cmd_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            power_reg  <= lqm_pkg::PowerReset;
            period_reg <= lqm_pkg::PeriodReset;
            count_reg  <= '0;
            hist0_reg  <= '0;
            hist1_reg  <= '0;
            energy_reg <= '0;
            vis_reg    <= '0;
            fmean_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            cmd_reg    <= cmd_next;
            ov_reg     <= ov_next;
            count_reg  <= count_next;
            hist0_reg  <= hist0_next;
            hist1_reg  <= hist1_next;
            energy_reg <= energy_next;
            vis_reg    <= vis_next;
            fmean_reg  <= fmean_next;
            if (cfg_we && (cfg_index == lqm_pkg::CfgIdxPower))
                power_reg <= cfg_data[lqm_pkg::PowerW-1:0];
            if (cfg_we && (cfg_index == lqm_pkg::CfgIdxPeriod))
                period_reg <= cfg_data[lqm_pkg::PeriodW-1:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lux_reg   <= lux_next;
        ref_reg   <= ref_next;
        duty_reg  <= duty_next;
        fsize_reg <= fsize_next;
        oe_reg    <= oe_next;
        ovis_reg  <= ovis_next;
        ofl_reg   <= ofl_next;
        ocnt_reg  <= ocnt_next;
    end

    assign out_res.valid            = ov_reg;
    assign out_res.energy_nj        = oe_reg;
    assign out_res.visibility_error = ovis_reg;
    assign out_res.flicker_error    = ofl_reg;
    assign out_res.sample_count     = ocnt_reg;

endmodule
